### hdl/prl_pkg.sv
// Shared types, codes and sizes for the positional record list unit.
package prl_pkg;

    // Field widths fixed by the interface
    localparam int REQ_W    = 3;
    localparam int POS_W    = 7;
    localparam int ID_W     = 32;
    localparam int NAME_W   = 64;
    localparam int MARK_W   = 8;
    localparam int STATUS_W = 2;

    // Default list depth (range 2..127, bounded by the position width)
    localparam int DEPTH_DEF = 64;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_CLEAR     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FIND_ID   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_FIND_NAME = 3'd4;
    localparam logic [REQ_W-1:0] REQ_FIND_MARK = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd3;

    // Classified command kinds
    typedef enum logic [2:0] {
        CMD_CLEAR,
        CMD_INSERT,
        CMD_DELETE,
        CMD_FIND_ID,
        CMD_FIND_NAME,
        CMD_FIND_MARK,
        CMD_REJECT
    } cmd_kind_t;

    // One stored record
    typedef struct packed {
        logic signed [ID_W-1:0] id;
        logic [NAME_W-1:0]      name;
        logic [MARK_W-1:0]      mark;
    } rec_t;

    // Command handed from front to back; count is the list length before it
    typedef struct packed {
        cmd_kind_t           kind;
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    pos;
        logic [POS_W-1:0]    count;
        rec_t                rec;
    } cmd_t;

endpackage

### hdl/prl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module prl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port, data held while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/prl_front.sv
// Front end: accepts request items, checks them against a shadow length, builds commands.
module prl_front import prl_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  logic [REQ_W-1:0]         req_type,
    input  logic [POS_W-1:0]         position,
    input  logic signed [ID_W-1:0]   student_id,
    input  logic [NAME_W-1:0]        student_name,
    input  logic [MARK_W-1:0]        student_mark,
    input  logic                     q_full,
    output logic                     push,
    output cmd_t                     cmd
);

    // List length as it will be once every queued command has run
    logic [POS_W-1:0] count_reg;
    logic [POS_W-1:0] count_next;

    logic             accept;
    logic             code_ok;
    logic [POS_W:0]   cnt_x;
    logic [POS_W:0]   pos_x;
    logic             list_full;
    logic             ins_bad;
    logic             del_bad;

    assign req_stall = q_full;
    assign accept    = req_valid && !q_full;
    assign push      = accept && code_ok;

    assign cnt_x     = {1'b0, count_reg};
    assign pos_x     = {1'b0, position};
    assign list_full = cnt_x >= (POS_W+1)'(DEPTH);
    assign ins_bad   = (position == '0) || (pos_x > cnt_x + (POS_W+1)'(1));
    assign del_bad   = (position == '0) || (pos_x > cnt_x);

    // Classify the request
    always_comb
    begin
        code_ok        = 1'b1;
        count_next     = count_reg;
        cmd.kind       = CMD_REJECT;
        cmd.status     = ST_OK;
        cmd.pos        = position;
        cmd.count      = count_reg;
        cmd.rec.id     = student_id;
        cmd.rec.name   = student_name;
        cmd.rec.mark   = student_mark;
        unique case (req_type)
            REQ_CLEAR:
            begin
                cmd.kind   = CMD_CLEAR;
                count_next = '0;
            end
            REQ_INSERT:
            begin
                if (list_full)
                begin
                    cmd.status = ST_FULL;
                end
                else if (ins_bad)
                begin
                    cmd.status = ST_BAD_POS;
                end
                else
                begin
                    cmd.kind   = CMD_INSERT;
                    count_next = count_reg + POS_W'(1);
                end
            end
            REQ_DELETE:
            begin
                if (del_bad)
                begin
                    cmd.status = ST_BAD_POS;
                end
                else
                begin
                    cmd.kind   = CMD_DELETE;
                    count_next = count_reg - POS_W'(1);
                end
            end
            REQ_FIND_ID:   cmd.kind = CMD_FIND_ID;
            REQ_FIND_NAME: cmd.kind = CMD_FIND_NAME;
            REQ_FIND_MARK: cmd.kind = CMD_FIND_MARK;
            default:       code_ok  = 1'b0;
        endcase
    end

    // Shadow length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (push)
        begin
            count_reg <= count_next;
        end
    end

endmodule

### hdl/prl_queue.sv
// Short command queue between front and back.
module prl_queue import prl_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic q_valid,
    output cmd_t q_cmd
);

    localparam int QAW = $clog2(QUEUE_DEPTH);

    cmd_t             entries_reg [QUEUE_DEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW:0]     fill_reg;

    assign full    = fill_reg == (QAW+1)'(QUEUE_DEPTH);
    assign q_valid = fill_reg != '0;
    assign q_cmd   = entries_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + (QAW+1)'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - (QAW+1)'(1);
            end
        end
    end

endmodule

### hdl/prl_back.sv
// Back end: walks the record memory for shifts and searches and drives the result register.
module prl_back import prl_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  cmd_t                       q_cmd,
    output logic                       pop,
    output logic                       ram_we,
    output logic [$clog2(DEPTH)-1:0]   ram_waddr,
    output rec_t                       ram_wdata,
    output logic                       ram_re,
    output logic [$clog2(DEPTH)-1:0]   ram_raddr,
    input  rec_t                       ram_rdata,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output logic [STATUS_W-1:0]        status,
    output logic [POS_W-1:0]           found_position,
    output logic signed [ID_W-1:0]     found_id,
    output logic [NAME_W-1:0]          found_name,
    output logic [MARK_W-1:0]          found_mark,
    output logic                       last_result
);

    localparam int AW = $clog2(DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GRAB,
        ST_MOVE,
        ST_FINISH,
        ST_SCAN,
        ST_REPORT
    } state_t;

    state_t               state_reg,     state_next;
    cmd_kind_t            kind_reg,      kind_next;
    logic                 up_reg,        up_next;
    logic [AW-1:0]        ra_reg,        ra_next;
    logic [AW-1:0]        end_reg,       end_next;
    logic [AW-1:0]        pa_reg,        pa_next;
    logic                 rd_more_reg,   rd_more_next;
    logic                 pend_reg,      pend_next;
    logic                 hit_reg,       hit_next;
    logic [POS_W-1:0]     pos_reg,       pos_next;
    rec_t                 rec_reg,       rec_next;
    rec_t                 key_reg,       key_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0]  status_reg,    status_next;
    logic [POS_W-1:0]     fpos_reg,      fpos_next;
    rec_t                 frec_reg,      frec_next;
    logic                 last_reg,      last_next;

    logic                 out_free;
    logic                 match;
    logic                 hit_now;
    logic                 scan_hold;
    logic [POS_W-1:0]     cnt_dec;
    logic [POS_W-1:0]     pos_dec;
    logic [POS_W-1:0]     held_dec;

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign cnt_dec  = q_cmd.count - POS_W'(1);
    assign pos_dec  = q_cmd.pos - POS_W'(1);
    assign held_dec = pos_reg - POS_W'(1);

    // Key compare on the word just read
    always_comb
    begin
        case (kind_reg)
            CMD_FIND_ID:   match = ram_rdata.id == key_reg.id;
            CMD_FIND_NAME: match = ram_rdata.name == key_reg.name;
            CMD_FIND_MARK: match = ram_rdata.mark == key_reg.mark;
            default:       match = 1'b0;
        endcase
    end

    assign hit_now   = pend_reg && match;
    assign scan_hold = hit_now && hit_reg && !out_free;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        up_next        = up_reg;
        ra_next        = ra_reg;
        end_next       = end_reg;
        pa_next        = pa_reg;
        rd_more_next   = rd_more_reg;
        pend_next      = pend_reg;
        hit_next       = hit_reg;
        pos_next       = pos_reg;
        rec_next       = rec_reg;
        key_next       = key_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        status_next    = status_reg;
        fpos_next      = fpos_reg;
        frec_next      = frec_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = pa_reg;
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = ra_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    kind_next = q_cmd.kind;
                    unique case (q_cmd.kind)
                        CMD_CLEAR,
                        CMD_REJECT:
                        begin
                            if (out_free)
                            begin
                                pop            = 1'b1;
                                rsp_valid_next = 1'b1;
                                status_next    = (q_cmd.kind == CMD_CLEAR) ? ST_OK
                                                                           : q_cmd.status;
                                fpos_next      = '0;
                                frec_next      = '0;
                                last_next      = 1'b1;
                            end
                        end
                        CMD_INSERT:
                        begin
                            pop          = 1'b1;
                            rec_next     = q_cmd.rec;
                            pos_next     = q_cmd.pos;
                            up_next      = 1'b1;
                            ra_next      = cnt_dec[AW-1:0];
                            end_next     = pos_dec[AW-1:0];
                            rd_more_next = q_cmd.count >= q_cmd.pos;
                            pend_next    = 1'b0;
                            state_next   = ST_MOVE;
                        end
                        CMD_DELETE:
                        begin
                            pop          = 1'b1;
                            ram_re       = 1'b1;
                            ram_raddr    = pos_dec[AW-1:0];
                            pos_next     = q_cmd.pos;
                            up_next      = 1'b0;
                            ra_next      = q_cmd.pos[AW-1:0];
                            end_next     = cnt_dec[AW-1:0];
                            rd_more_next = q_cmd.pos < q_cmd.count;
                            pend_next    = 1'b0;
                            state_next   = ST_GRAB;
                        end
                        CMD_FIND_ID,
                        CMD_FIND_NAME,
                        CMD_FIND_MARK:
                        begin
                            pop          = 1'b1;
                            key_next     = q_cmd.rec;
                            ra_next      = '0;
                            end_next     = cnt_dec[AW-1:0];
                            rd_more_next = q_cmd.count != '0;
                            pend_next    = 1'b0;
                            hit_next     = 1'b0;
                            state_next   = ST_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Removed record arrives from memory
            ST_GRAB:
            begin
                rec_next   = ram_rdata;
                state_next = ST_MOVE;
            end

            // One entry moved per cycle: read one slot, write the previous read one over
            ST_MOVE:
            begin
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = up_reg ? pa_reg + AW'(1) : pa_reg - AW'(1);
                    ram_wdata = ram_rdata;
                end
                if (rd_more_reg)
                begin
                    ram_re    = 1'b1;
                    pend_next = 1'b1;
                    pa_next   = ra_reg;
                    if (ra_reg == end_reg)
                    begin
                        rd_more_next = 1'b0;
                    end
                    else
                    begin
                        ra_next = up_reg ? ra_reg - AW'(1) : ra_reg + AW'(1);
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (!rd_more_reg && !pend_reg)
                begin
                    state_next = ST_FINISH;
                end
            end

            // Place the new record (insert) and report
            ST_FINISH:
            begin
                if (out_free)
                begin
                    if (kind_reg == CMD_INSERT)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = held_dec[AW-1:0];
                        ram_wdata = rec_reg;
                    end
                    rsp_valid_next = 1'b1;
                    status_next    = ST_OK;
                    fpos_next      = pos_reg;
                    frec_next      = rec_reg;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            // One entry compared per cycle unless the output stalls; a hit is held until the next hit
            ST_SCAN:
            begin
                if (!scan_hold)
                begin
                    if (hit_now && hit_reg)
                    begin
                        rsp_valid_next = 1'b1;
                        status_next    = ST_OK;
                        fpos_next      = pos_reg;
                        frec_next      = rec_reg;
                        last_next      = 1'b0;
                    end
                    if (hit_now)
                    begin
                        rec_next = ram_rdata;
                        pos_next = POS_W'(pa_reg) + POS_W'(1);
                        hit_next = 1'b1;
                    end
                    if (rd_more_reg)
                    begin
                        ram_re    = 1'b1;
                        pend_next = 1'b1;
                        pa_next   = ra_reg;
                        if (ra_reg == end_reg)
                        begin
                            rd_more_next = 1'b0;
                        end
                        else
                        begin
                            ra_next = ra_reg + AW'(1);
                        end
                    end
                    else
                    begin
                        pend_next = 1'b0;
                    end
                    if (!rd_more_reg && !pend_reg)
                    begin
                        state_next = ST_REPORT;
                    end
                end
            end

            // Final search result: the held hit, or not found
            ST_REPORT:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    last_next      = 1'b1;
                    if (hit_reg)
                    begin
                        status_next = ST_OK;
                        fpos_next   = pos_reg;
                        frec_next   = rec_reg;
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                        fpos_next   = '0;
                        frec_next   = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= CMD_CLEAR;
            up_reg        <= 1'b0;
            ra_reg        <= '0;
            end_reg       <= '0;
            pa_reg        <= '0;
            rd_more_reg   <= 1'b0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            pos_reg       <= '0;
            rec_reg       <= '0;
            key_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            fpos_reg      <= '0;
            frec_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            up_reg        <= up_next;
            ra_reg        <= ra_next;
            end_reg       <= end_next;
            pa_reg        <= pa_next;
            rd_more_reg   <= rd_more_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
            pos_reg       <= pos_next;
            rec_reg       <= rec_next;
            key_reg       <= key_next;
            rsp_valid_reg <= rsp_valid_next;
            status_reg    <= status_next;
            fpos_reg      <= fpos_next;
            frec_reg      <= frec_next;
            last_reg      <= last_next;
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign status         = status_reg;
    assign found_position = fpos_reg;
    assign found_id       = frec_reg.id;
    assign found_name     = frec_reg.name;
    assign found_mark     = frec_reg.mark;
    assign last_result    = last_reg;

endmodule

### hdl/positional_record_list_unit.sv
// Clear and rejected requests are answered by the idle back end without a memory walk; insert
// and delete shift the entries behind the position one per cycle through the RAM, and a search
// reads every entry from the head. Search results leave at up to one per cycle unless stalled.
// Throughput: one request in the back end at a time; a two-entry command queue lets the front
// take up to two more requests meanwhile.
// Reset (rst_n low, asynchronous) empties the list; record memory needs no clearing.
module positional_record_list_unit import prl_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  logic [REQ_W-1:0]         req_type,
    input  logic [POS_W-1:0]         position,
    input  logic signed [ID_W-1:0]   student_id,
    input  logic [NAME_W-1:0]        student_name,
    input  logic [MARK_W-1:0]        student_mark,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output logic [STATUS_W-1:0]      status,
    output logic [POS_W-1:0]         found_position,
    output logic signed [ID_W-1:0]   found_id,
    output logic [NAME_W-1:0]        found_name,
    output logic [MARK_W-1:0]        found_mark,
    output logic                     last_result
);

    localparam int AW = $clog2(DEPTH);

    logic          push;
    cmd_t          push_cmd;
    logic          q_full;
    logic          pop;
    logic          q_valid;
    cmd_t          q_cmd;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    rec_t          ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    rec_t          ram_rdata;

    prl_front #(.DEPTH(DEPTH)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req_type     (req_type),
        .position     (position),
        .student_id   (student_id),
        .student_name (student_name),
        .student_mark (student_mark),
        .q_full       (q_full),
        .push         (push),
        .cmd          (push_cmd)
    );

    prl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    prl_ram #(.WIDTH($bits(rec_t)), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    prl_back #(.DEPTH(DEPTH)) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_cmd          (q_cmd),
        .pop            (pop),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_re         (ram_re),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .status         (status),
        .found_position (found_position),
        .found_id       (found_id),
        .found_name     (found_name),
        .found_mark     (found_mark),
        .last_result    (last_result)
    );

endmodule

### hdl/prl_checker.sv
// Port-level checks on the result channel of the positional record list unit.
module prl_port_checks import prl_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    rsp_valid,
    input logic                    rsp_stall,
    input logic [STATUS_W-1:0]     status,
    input logic [POS_W-1:0]        found_position,
    input logic signed [ID_W-1:0]  found_id,
    input logic [NAME_W-1:0]       found_name,
    input logic [MARK_W-1:0]       found_mark,
    input logic                    last_result
);

    // A stalled item stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result item dropped while stalled");

    // A stalled item keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(status) && $stable(found_position)
            && $stable(found_id) && $stable(found_name) && $stable(found_mark)
            && $stable(last_result))
        else $error("result item changed while stalled");

    // Errors and not-found are single, empty results
    a_error_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ST_OK |-> found_position == '0 && found_id == '0
            && found_name == '0 && found_mark == '0 && last_result)
        else $error("error result carries a record or is not final");

    // Positions stay within the list depth
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> found_position <= POS_W'(DEPTH))
        else $error("result position beyond list depth");

endmodule

bind positional_record_list_unit prl_port_checks #(.DEPTH(DEPTH)) u_prl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .status         (status),
    .found_position (found_position),
    .found_id       (found_id),
    .found_name     (found_name),
    .found_mark     (found_mark),
    .last_result    (last_result)
);
